[sv/jfc_pkg.sv]
// jfc_pkg: shared types, widths and codes for the jpeg frame capture framer
// used by jfc_front, jfc_queue, jfc_back and jpeg_frame_capture_framer
// no dependencies
package jfc_pkg;

   // field widths
   localparam int OP_W     = 2;
   localparam int DATA_W   = 8;
   localparam int ADDR_W   = 18;
   localparam int LEN_W    = 18;
   localparam int COUNT_W  = 24;
   localparam int STATUS_W = 3;

   // stream widths, packed to whole bytes
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 80;

   // parameter defaults
   localparam int NUM_SLOTS_DEF   = 2;
   localparam int FRAME_BYTES_DEF = 131072;
   localparam int QUEUE_DEPTH_DEF = 2;

   // register reset value
   localparam logic [LEN_W-1:0] FRAME_LIMIT_RESET = 18'd131072;

   // jpeg marker bytes
   localparam logic [DATA_W-1:0] MARKER_PREFIX = 8'hFF;
   localparam logic [DATA_W-1:0] MARKER_SOI    = 8'hD8;
   localparam logic [DATA_W-1:0] MARKER_EOI    = 8'hD9;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // input op codes
   typedef enum logic [OP_W-1:0] {
      OP_DATA      = 2'd0,
      OP_FRAME_END = 2'd1,
      OP_RELEASE   = 2'd2
   } jfc_op_type;

   // frame status codes; the front marks a good frame as queued and the
   // back turns it into dropped when the ring is full
   typedef enum logic [STATUS_W-1:0] {
      STATUS_QUEUED    = 3'd0,
      STATUS_DROPPED   = 3'd1,
      STATUS_BAD_START = 3'd2,
      STATUS_NO_END    = 3'd3,
      STATUS_OVERFLOW  = 3'd4,
      STATUS_ARMED     = 3'd5
   } jfc_status_type;

   // classified item passed from front to back
   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic               write_enable;
      logic [ADDR_W-1:0]  offset;
      logic [DATA_W-1:0]  write_data;
      logic               frame_done;
      jfc_status_type     frame_status;
      logic [COUNT_W-1:0] frame_length;
   } jfc_entry_type;

   // result beat, last field in the lowest bits
   typedef struct packed {
      logic [4:0]         pad;
      logic [LEN_W-1:0]   ready_length;
      logic               ready_slot;
      logic               frame_ready;
      logic [COUNT_W-1:0] frame_length;
      logic [STATUS_W-1:0] frame_status;
      logic               frame_done;
      logic [DATA_W-1:0]  write_data;
      logic [ADDR_W-1:0]  write_address;
      logic               write_enable;
   } jfc_rsp_type;

endpackage

[sv/jpeg_frame_capture_framer.sv]
// jpeg_frame_capture_framer: top level of the jpeg frame capture framer
// depends on jfc_pkg, jfc_front, jfc_queue and jfc_back
//
// Usage:
//   req channel: one beat per camera byte (op data), frame end (vsync) or
//     release of the oldest queued frame. rsp channel: exactly one result
//     beat per request beat, in order, carrying the frame memory write
//     (enable, address, data), the frame-end verdict and the ring state.
//   csr port: csr_write_enable with csr_write_data sets the frame limit;
//     write it only while no request is in flight.
//   Path: a request beat passes a queue entry, then the result register,
//     before its result beat is presented on rsp. Throughput: one beat
//     per cycle while rsp is not stalled, set by the front's capture
//     update and the back's ring update.
//   Stall: the result register holds while rsp_tready is low; the queue
//     between front and back absorbs up to QUEUE_DEPTH beats before
//     req_tready drops. Nothing is lost or repeated.
//   Reset (synchronous): capture is disarmed until the first frame end,
//     the ring is empty, the queue is empty and the limit returns to 131072.
module jpeg_frame_capture_framer #(
   parameter int NUM_SLOTS   = jfc_pkg::NUM_SLOTS_DEF,
   parameter int FRAME_BYTES = jfc_pkg::FRAME_BYTES_DEF,
   parameter int QUEUE_DEPTH = jfc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [1:0] op, [9:2] data, [15:10] zero
   input  logic [jfc_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] write_enable, [18:1] write_address, [26:19] write_data,
   // [27] frame_done, [30:28] frame_status, [54:31] frame_length,
   // [55] frame_ready, [56] ready_slot, [74:57] ready_length, [79:75] zero
   output logic [jfc_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // frame limit register
   input  logic                               csr_write_enable,
   input  logic [jfc_pkg::LEN_W-1:0]          csr_write_data
);
   import jfc_pkg::*;

   logic          accept;
   logic          queue_full;
   logic          queue_not_empty;
   logic          queue_pop;
   jfc_entry_type front_entry;
   jfc_entry_type back_entry;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && !queue_full;

   // classify beats and track capture state
   jfc_front #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .op               (req_tdata[OP_W-1:0]),
      .data             (req_tdata[OP_W+DATA_W-1:OP_W]),
      .entry            (front_entry)
   );

   // decouple front and back
   jfc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_entry),
      .pop       (queue_pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .pop_data  (back_entry)
   );

   // ring handling and result register
   jfc_back #(
      .NUM_SLOTS   (NUM_SLOTS),
      .FRAME_BYTES (FRAME_BYTES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (queue_not_empty),
      .entry       (back_entry),
      .pop         (queue_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

[sv/jfc_front.sv]
// jfc_front: capture state, byte classification and frame-end checks
// depends on jfc_pkg; feeds jfc_queue with one jfc_entry_type per beat
module jfc_front #(
   parameter int FRAME_BYTES = jfc_pkg::FRAME_BYTES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [jfc_pkg::LEN_W-1:0]    csr_write_data,
   input  logic                         accept,
   input  logic [jfc_pkg::OP_W-1:0]     op,
   input  logic [jfc_pkg::DATA_W-1:0]   data,
   output jfc_pkg::jfc_entry_type       entry
);
   import jfc_pkg::*;

   localparam logic [COUNT_W-1:0] FRAME_BYTES_W = COUNT_W'(FRAME_BYTES);

   logic [LEN_W-1:0]     limit_ff;
   logic                 running_ff,  running_in;
   logic [COUNT_W-1:0]   count_ff,    count_in;
   logic [DATA_W-1:0]    first_ff,    first_in;
   logic [DATA_W-1:0]    second_ff,   second_in;
   logic                 prev_ff_ff,  prev_ff_in;
   logic [LEN_W-1:0]     marker_ff,   marker_in;
   logic [COUNT_W-1:0]   lim;
   logic                 in_range;

   // effective limit never exceeds the slot size
   assign lim = (COUNT_W'(limit_ff) < FRAME_BYTES_W) ? COUNT_W'(limit_ff) : FRAME_BYTES_W;
   assign in_range = (count_ff < lim);

   // next capture state and classified entry
   always_comb begin
      running_in = running_ff;
      count_in   = count_ff;
      first_in   = first_ff;
      second_in  = second_ff;
      prev_ff_in = prev_ff_ff;
      marker_in  = marker_ff;

      entry              = '0;
      entry.op           = op;
      entry.frame_status = STATUS_QUEUED;

      case (op)
         OP_DATA: begin
            if (running_ff) begin
               if (count_ff == '0) begin
                  first_in = data;
               end else if (count_ff == COUNT_W'(1)) begin
                  second_in = data;
               end
               if (in_range) begin
                  entry.write_enable = 1'b1;
                  entry.offset       = count_ff[ADDR_W-1:0];
                  entry.write_data   = data;
                  if (prev_ff_ff && data == MARKER_EOI && count_ff != '0) begin
                     marker_in = count_ff[LEN_W-1:0] + 1'b1;
                  end
               end
               prev_ff_in = (data == MARKER_PREFIX);
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         OP_FRAME_END: begin
            entry.frame_done = 1'b1;
            if (!running_ff) begin
               running_in         = 1'b1;
               entry.frame_status = STATUS_ARMED;
            end else if (count_ff > lim) begin
               entry.frame_status = STATUS_OVERFLOW;
               entry.frame_length = count_ff;
            end else if (count_ff < COUNT_W'(2) || first_ff != MARKER_PREFIX ||
                         second_ff != MARKER_SOI) begin
               entry.frame_status = STATUS_BAD_START;
               entry.frame_length = count_ff;
            end else if (marker_ff == '0) begin
               entry.frame_status = STATUS_NO_END;
               entry.frame_length = count_ff;
            end else begin
               entry.frame_status = STATUS_QUEUED;
               entry.frame_length = COUNT_W'(marker_ff);
            end
            // start a fresh frame
            count_in   = '0;
            first_in   = '0;
            second_in  = '0;
            prev_ff_in = 1'b0;
            marker_in  = '0;
         end
         default: begin
         end
      endcase
   end

   // frame limit register; the user must write it only while idle, the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= FRAME_LIMIT_RESET;
      end else if (csr_write_enable) begin
         limit_ff <= csr_write_data;
      end
   end

   // capture state
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         count_ff   <= '0;
         first_ff   <= '0;
         second_ff  <= '0;
         prev_ff_ff <= 1'b0;
         marker_ff  <= '0;
      end else if (accept) begin
         running_ff <= running_in;
         count_ff   <= count_in;
         first_ff   <= first_in;
         second_ff  <= second_in;
         prev_ff_ff <= prev_ff_in;
         marker_ff  <= marker_in;
      end
   end

endmodule

[sv/jfc_queue.sv]
// jfc_queue: short register fifo of classified entries between front and back
// depends on jfc_pkg for jfc_entry_type
module jfc_queue #(
   parameter int DEPTH = jfc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  jfc_pkg::jfc_entry_type push_data,
   input  logic                   pop,
   output logic                   full,
   output logic                   not_empty,
   output jfc_pkg::jfc_entry_type pop_data
);
   import jfc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   jfc_entry_type        store_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff,  count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = store_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[sv/jfc_back.sv]
// jfc_back: slot ring, write address forming and the registered result beat
// depends on jfc_pkg; takes entries from jfc_queue
module jfc_back #(
   parameter int NUM_SLOTS   = jfc_pkg::NUM_SLOTS_DEF,
   parameter int FRAME_BYTES = jfc_pkg::FRAME_BYTES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               entry_valid,
   input  jfc_pkg::jfc_entry_type             entry,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [jfc_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);
   import jfc_pkg::*;

   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);
   // slot base advance, kept modulo the address width
   localparam logic [ADDR_W-1:0] SLOT_STRIDE = ADDR_W'(FRAME_BYTES % (2 ** ADDR_W));

   logic [SLOT_W-1:0]  write_index_ff, write_index_in;
   logic [SLOT_W-1:0]  read_index_ff,  read_index_in;
   logic [ADDR_W-1:0]  base_ff,        base_in;
   logic [LEN_W-1:0]   slot_length_ff [NUM_SLOTS];
   logic               rsp_valid_ff;
   jfc_rsp_type        rsp_ff,         rsp_in;
   logic [SLOT_W-1:0]  write_next;
   logic [SLOT_W-1:0]  read_next;
   logic               store;
   logic               ready;
   logic [LEN_W-1:0]   head_length;

   assign pop        = entry_valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   assign write_next = (write_index_ff == SLOT_LAST) ? '0 : write_index_ff + 1'b1;
   assign read_next  = (read_index_ff == SLOT_LAST) ? '0 : read_index_ff + 1'b1;

   // ring update for the entry at the head of the queue
   always_comb begin
      write_index_in = write_index_ff;
      read_index_in  = read_index_ff;
      base_in        = base_ff;
      store          = 1'b0;

      rsp_in               = '0;
      rsp_in.write_enable  = entry.write_enable;
      rsp_in.write_address = entry.write_enable ? base_ff + entry.offset : '0;
      rsp_in.write_data    = entry.write_data;
      rsp_in.frame_done    = entry.frame_done;
      rsp_in.frame_status  = entry.frame_status;
      rsp_in.frame_length  = entry.frame_length;

      case (entry.op)
         OP_FRAME_END: begin
            if (entry.frame_status == STATUS_QUEUED) begin
               if (write_next == read_index_ff) begin
                  rsp_in.frame_status = STATUS_DROPPED;
               end else begin
                  store          = 1'b1;
                  write_index_in = write_next;
                  base_in        = (write_next == '0) ? '0 : base_ff + SLOT_STRIDE;
               end
            end
         end
         OP_RELEASE: begin
            if (read_index_ff != write_index_ff) begin
               read_index_in = read_next;
            end
         end
         default: begin
         end
      endcase

      // ring view after this beat, with bypass of a slot written now
      ready = (read_index_in != write_index_in);
      if (store && write_index_ff == read_index_in) begin
         head_length = entry.frame_length[LEN_W-1:0];
      end else begin
         head_length = slot_length_ff[read_index_in];
      end
      rsp_in.frame_ready  = ready;
      rsp_in.ready_slot   = read_index_in[0];
      rsp_in.ready_length = ready ? head_length : '0;
   end

   // ring indexes and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         write_index_ff <= '0;
         read_index_ff  <= '0;
         base_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (pop) begin
            write_index_ff <= write_index_in;
            read_index_ff  <= read_index_in;
            base_ff        <= base_in;
         end
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // slot lengths and result payload
   always_ff @(posedge clock) begin
      if (pop && store) begin
         slot_length_ff[write_index_ff] <= entry.frame_length[LEN_W-1:0];
      end
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

[tb/jpeg_frame_capture_framer_tb.sv]
// jpeg_frame_capture_framer_tb: self-checking testbench for the frame capture framer
// drives camera bytes, frame ends and releases, predicts every result beat in order
// depends on jfc_pkg and jpeg_frame_capture_framer
`timescale 1ns / 1ps

module jpeg_frame_capture_framer_tb;
   import jfc_pkg::*;

   localparam int SLOTS       = NUM_SLOTS_DEF;
   localparam int FRAME_SIZE  = FRAME_BYTES_DEF;
   localparam int COUNT_LIMIT = 2**COUNT_W - 1;

   // op code the block does not define
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam logic [LEN_W-1:0] LIMIT_MAX = '1;

   localparam int RANDOM_BEATS_PER_PHASE = 130;
   localparam int NUM_PHASES             = 6;
   localparam int LONG_HOLD_CYCLES       = 300;
   localparam int HOLD_BACKLOG           = 100;
   localparam int DRAIN_CYCLES           = 8;
   localparam int TIMEOUT_NS             = 40_000_000;

   // one request beat, optionally with a typed-in expected result
   typedef struct {
      logic [OP_W-1:0]   op;
      logic [DATA_W-1:0] data;
      bit                pinned;
      jfc_rsp_type       want;
   } camera_beat_type;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_tvalid       = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata        = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready       = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_write_enable = 1'b0;
   logic [LEN_W-1:0]       csr_write_data   = '0;

   camera_beat_type camera_beats[$];
   camera_beat_type directed_rows[$];
   jfc_rsp_type     expected_results[$];

   // capture model state
   logic [LEN_W-1:0]  limit_reg = FRAME_LIMIT_RESET;
   bit                armed;
   int                bytes_seen;
   logic [DATA_W-1:0] soi_first;
   logic [DATA_W-1:0] soi_second;
   bit                last_ff;
   int                eoi_len;
   int                fill_slot;
   int                drain_slot;
   int                slot_len[SLOTS];

   // run bookkeeping
   bit req_beat_taken;
   bit hold_off;
   int mismatches;
   int beats_queued;
   int beats_taken;
   int results_checked;
   int input_stall_cycles;
   int status_seen[8];

   // sender pacing
   int burst_left;
   int gap_left;

   // receiver pacing
   int stall_span;
   int stall_pct;

   jpeg_frame_capture_framer DUT (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // next state of the framer for one beat, returns its result
   function automatic jfc_rsp_type capture_step(input logic [OP_W-1:0] op,
                                                input logic [DATA_W-1:0] data);
      jfc_rsp_type r;
      int          cap;
      int          next_slot;
      r   = '0;
      cap = (int'(limit_reg) < FRAME_SIZE) ? int'(limit_reg) : FRAME_SIZE;
      case (op)
         OP_DATA: if (armed) begin
            if (bytes_seen == 0)
               soi_first = data;
            else if (bytes_seen == 1)
               soi_second = data;
            if (bytes_seen < cap) begin
               r.write_enable  = 1'b1;
               r.write_address = ADDR_W'(fill_slot * FRAME_SIZE + bytes_seen);
               r.write_data    = data;
               // eoi counts only when both bytes land in the slot
               if (last_ff && data == MARKER_EOI && bytes_seen >= 1)
                  eoi_len = bytes_seen + 1;
            end
            last_ff = (data == MARKER_PREFIX);
            if (bytes_seen < COUNT_LIMIT)
               bytes_seen++;
         end
         OP_FRAME_END: begin
            r.frame_done = 1'b1;
            if (!armed) begin
               armed          = 1'b1;
               r.frame_status = STATUS_ARMED;
            end else if (bytes_seen > cap) begin
               r.frame_status = STATUS_OVERFLOW;
               r.frame_length = COUNT_W'(bytes_seen);
            end else if (bytes_seen < 2 || soi_first != MARKER_PREFIX
                         || soi_second != MARKER_SOI) begin
               r.frame_status = STATUS_BAD_START;
               r.frame_length = COUNT_W'(bytes_seen);
            end else if (eoi_len == 0) begin
               r.frame_status = STATUS_NO_END;
               r.frame_length = COUNT_W'(bytes_seen);
            end else begin
               r.frame_length = COUNT_W'(eoi_len);
               next_slot      = (fill_slot + 1) % SLOTS;
               if (next_slot == drain_slot) begin
                  r.frame_status = STATUS_DROPPED;
               end else begin
                  slot_len[fill_slot] = eoi_len;
                  fill_slot           = next_slot;
                  r.frame_status      = STATUS_QUEUED;
               end
            end
            bytes_seen = 0;
            soi_first  = '0;
            soi_second = '0;
            last_ff    = 1'b0;
            eoi_len    = 0;
         end
         OP_RELEASE: if (drain_slot != fill_slot)
            drain_slot = (drain_slot + 1) % SLOTS;
         default: ;
      endcase
      r.frame_ready  = (drain_slot != fill_slot);
      r.ready_slot   = drain_slot[0];
      r.ready_length = r.frame_ready ? LEN_W'(slot_len[drain_slot]) : '0;
      return r;
   endfunction

   function automatic jfc_rsp_type mk_result(input bit we, input int addr,
                                             input logic [DATA_W-1:0] wdata,
                                             input bit done, input jfc_status_type status,
                                             input int flen, input bit rdy,
                                             input bit slot, input int rlen);
      jfc_rsp_type r;
      r               = '0;
      r.write_enable  = we;
      r.write_address = ADDR_W'(addr);
      r.write_data    = wdata;
      r.frame_done    = done;
      r.frame_status  = status;
      r.frame_length  = COUNT_W'(flen);
      r.frame_ready   = rdy;
      r.ready_slot    = slot;
      r.ready_length  = LEN_W'(rlen);
      return r;
   endfunction

   task automatic add_row(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] data,
                          input jfc_rsp_type want);
      camera_beat_type b;
      b.op     = op;
      b.data   = data;
      b.pinned = 1'b1;
      b.want   = want;
      directed_rows.push_back(b);
   endtask

   task automatic queue_beat(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] data);
      camera_beat_type b;
      b.op     = op;
      b.data   = data;
      b.pinned = 1'b0;
      b.want   = '0;
      camera_beats.push_back(b);
      beats_queued++;
   endtask

   // random byte leaning toward marker values
   function automatic logic [DATA_W-1:0] camera_byte();
      case ($urandom_range(0, 5))
         0:       return MARKER_PREFIX;
         1:       return MARKER_EOI;
         2:       return MARKER_SOI;
         default: return DATA_W'($urandom_range(0, 255));
      endcase
   endfunction

   // one random sequence: mostly well-formed frames, the rest broken frames and noise
   task automatic queue_frame_traffic();
      int kind;
      int body;
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
         queue_beat(OP_DATA, MARKER_PREFIX);
         queue_beat(OP_DATA, MARKER_SOI);
         body = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 10);
         repeat (body) queue_beat(OP_DATA, camera_byte());
         if ($urandom_range(0, 4) != 0) begin
            queue_beat(OP_DATA, MARKER_PREFIX);
            queue_beat(OP_DATA, MARKER_EOI);
         end
         repeat ($urandom_range(0, 2)) queue_beat(OP_DATA, camera_byte());
         queue_beat(OP_FRAME_END, camera_byte());
         if ($urandom_range(0, 1) == 0)
            queue_beat(OP_RELEASE, camera_byte());
      end else if (kind < 72) begin
         repeat ($urandom_range(0, 8)) queue_beat(OP_DATA, camera_byte());
         queue_beat(OP_FRAME_END, camera_byte());
      end else if (kind < 87) begin
         queue_beat(OP_RELEASE, camera_byte());
      end else if (kind < 94) begin
         queue_beat(OP_UNUSED, camera_byte());
      end else begin
         // soi prefix followed by a random byte, usually not the soi code
         queue_beat(OP_DATA, MARKER_PREFIX);
         queue_beat(OP_DATA, camera_byte());
         repeat ($urandom_range(0, 6)) queue_beat(OP_DATA, camera_byte());
         queue_beat(OP_FRAME_END, camera_byte());
      end
   endtask

   task automatic wait_idle();
      while (camera_beats.size() != 0 || expected_results.size() != 0)
         @(posedge clock);
   endtask

   // limit register is only written with nothing in flight
   task automatic write_frame_limit(input logic [LEN_W-1:0] value);
      wait_idle();
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      limit_reg         = value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (want_v !== got_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
         mismatches++;
      end
   endtask

   // sender: bursts of beats with random gaps, valid held until the beat is taken
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_beat_taken)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (camera_beats.size() == 0) begin
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata  <= {{(REQ_TDATA_W - OP_W - DATA_W){1'b0}},
                           camera_beats[0].data, camera_beats[0].op};
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 39);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
   end

   // receiver: stall rate changes over random spans, plus the long hold
   always @(negedge clock) begin
      if (stall_span == 0) begin
         stall_span = $urandom_range(300, 800);
         case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 10;
            2:       stall_pct = 35;
            default: stall_pct = 60;
         endcase
      end else begin
         stall_span--;
      end
      rsp_tready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
   end

   // long receiver hold while the sender keeps a deep backlog
   initial begin
      while (reset || camera_beats.size() < HOLD_BACKLOG)
         @(posedge clock);
      hold_off = 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   // take request beats into the model, check result beats against it
   always @(posedge clock) begin : beat_monitor
      camera_beat_type item;
      jfc_rsp_type     want;
      jfc_rsp_type     got;
      req_beat_taken = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            item = camera_beats.pop_front();
            want = capture_step(item.op, item.data);
            if (item.pinned)
               want = item.want;
            expected_results.push_back(want);
            req_beat_taken = 1'b1;
            beats_taken++;
         end
         if (req_tvalid && !req_tready)
            input_stall_cycles++;
         if (rsp_tvalid && rsp_tready) begin
            got = jfc_rsp_type'(rsp_tdata);
            if (expected_results.size() == 0) begin
               $error("result beat with nothing expected: 0x%0h", rsp_tdata);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               check_field("write_enable", want.write_enable, got.write_enable);
               check_field("write_address", want.write_address, got.write_address);
               check_field("write_data", want.write_data, got.write_data);
               check_field("frame_done", want.frame_done, got.frame_done);
               check_field("frame_status", want.frame_status, got.frame_status);
               check_field("frame_length", want.frame_length, got.frame_length);
               check_field("frame_ready", want.frame_ready, got.frame_ready);
               check_field("ready_slot", want.ready_slot, got.ready_slot);
               check_field("ready_length", want.ready_length, got.ready_length);
               if (want.frame_done)
                  status_seen[int'(want.frame_status)]++;
               results_checked++;
            end
         end
      end
   end

   initial begin : run_sequence
      logic [LEN_W-1:0] phase_limits[NUM_PHASES];
      int               phase_start;

      // directed table, reset limit; rows before the first frame end are ignored beats
      add_row(OP_DATA, 8'h00, mk_result(0, 0, 8'h00, 0, STATUS_QUEUED, 0, 0, 0, 0));
      add_row(OP_DATA, 8'hFF, mk_result(0, 0, 8'h00, 0, STATUS_QUEUED, 0, 0, 0, 0));
      add_row(OP_RELEASE, 8'h00, mk_result(0, 0, 8'h00, 0, STATUS_QUEUED, 0, 0, 0, 0));
      add_row(OP_UNUSED, 8'hFF, mk_result(0, 0, 8'h00, 0, STATUS_QUEUED, 0, 0, 0, 0));
      add_row(OP_FRAME_END, 8'h00, mk_result(0, 0, 8'h00, 1, STATUS_ARMED, 0, 0, 0, 0));
      // empty frame, then a one-byte frame: both bad start
      add_row(OP_FRAME_END, 8'h00, mk_result(0, 0, 8'h00, 1, STATUS_BAD_START, 0, 0, 0, 0));
      add_row(OP_DATA, 8'hFF, mk_result(1, 0, 8'hFF, 0, STATUS_QUEUED, 0, 0, 0, 0));
      add_row(OP_FRAME_END, 8'h00, mk_result(0, 0, 8'h00, 1, STATUS_BAD_START, 1, 0, 0, 0));
      // good start but no end marker
      add_row(OP_DATA, 8'hFF, mk_result(1, 0, 8'hFF, 0, STATUS_QUEUED, 0, 0, 0, 0));
      add_row(OP_DATA, 8'hD8, mk_result(1, 1, 8'hD8, 0, STATUS_QUEUED, 0, 0, 0, 0));
      add_row(OP_DATA, 8'h5A, mk_result(1, 2, 8'h5A, 0, STATUS_QUEUED, 0, 0, 0, 0));
      add_row(OP_FRAME_END, 8'h00, mk_result(0, 0, 8'h00, 1, STATUS_NO_END, 3, 0, 0, 0));
      // good frame with a trailing byte, trimmed to 4 and queued in slot 0
      add_row(OP_DATA, 8'hFF, mk_result(1, 0, 8'hFF, 0, STATUS_QUEUED, 0, 0, 0, 0));
      add_row(OP_DATA, 8'hD8, mk_result(1, 1, 8'hD8, 0, STATUS_QUEUED, 0, 0, 0, 0));
      add_row(OP_DATA, 8'hFF, mk_result(1, 2, 8'hFF, 0, STATUS_QUEUED, 0, 0, 0, 0));
      add_row(OP_DATA, 8'hD9, mk_result(1, 3, 8'hD9, 0, STATUS_QUEUED, 0, 0, 0, 0));
      add_row(OP_DATA, 8'hA5, mk_result(1, 4, 8'hA5, 0, STATUS_QUEUED, 0, 0, 0, 0));
      add_row(OP_FRAME_END, 8'h00, mk_result(0, 0, 8'h00, 1, STATUS_QUEUED, 4, 1, 0, 4));
      // second good frame into slot 1, ring full so it is dropped
      add_row(OP_DATA, 8'hFF, mk_result(1, 'h20000, 8'hFF, 0, STATUS_QUEUED, 0, 1, 0, 4));
      add_row(OP_DATA, 8'hD8, mk_result(1, 'h20001, 8'hD8, 0, STATUS_QUEUED, 0, 1, 0, 4));
      add_row(OP_DATA, 8'hFF, mk_result(1, 'h20002, 8'hFF, 0, STATUS_QUEUED, 0, 1, 0, 4));
      add_row(OP_DATA, 8'hD9, mk_result(1, 'h20003, 8'hD9, 0, STATUS_QUEUED, 0, 1, 0, 4));
      add_row(OP_FRAME_END, 8'h00, mk_result(0, 0, 8'h00, 1, STATUS_DROPPED, 4, 1, 0, 4));
      // release the queued frame, then release on an empty ring
      add_row(OP_RELEASE, 8'h00, mk_result(0, 0, 8'h00, 0, STATUS_QUEUED, 0, 0, 1, 0));
      add_row(OP_RELEASE, 8'h00, mk_result(0, 0, 8'h00, 0, STATUS_QUEUED, 0, 0, 1, 0));

      phase_limits[0] = LIMIT_MAX;
      phase_limits[1] = LEN_W'(1);
      phase_limits[2] = '0;
      phase_limits[3] = LEN_W'($urandom_range(2, 40));
      phase_limits[4] = FRAME_LIMIT_RESET;
      phase_limits[5] = LEN_W'($urandom_range(2, 24));

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         camera_beats.push_back(directed_rows[i]);

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_frame_limit(phase_limits[p]);
         phase_start = beats_queued;
         while (beats_queued - phase_start < RANDOM_BEATS_PER_PHASE)
            queue_frame_traffic();
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d beats over %0d limit settings, %0d results checked",
               beats_taken, NUM_PHASES + 1, results_checked);
      $display("input stalled %0d cycles", input_stall_cycles);
      $display("frame ends: queued %0d dropped %0d bad start %0d no end %0d overflow %0d armed %0d",
               status_seen[STATUS_QUEUED], status_seen[STATUS_DROPPED],
               status_seen[STATUS_BAD_START], status_seen[STATUS_NO_END],
               status_seen[STATUS_OVERFLOW], status_seen[STATUS_ARMED]);
      if (mismatches == 0)
         $display("jpeg_frame_capture_framer_tb: clean");
      else
         $display("jpeg_frame_capture_framer_tb: errors");
      $finish;
   end

   // watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("jpeg_frame_capture_framer_tb: errors");
      $finish;
   end

endmodule
